/* design/yuv2argb_pkg.sv */
// Shared types, constants and register codes for the YUV to ARGB converter.
package yuv2argb_pkg;

    localparam int PixW     = 8;
    localparam int CoefW    = 16;
    localparam int FracBits = 8;
    localparam int ProdW    = CoefW + PixW + 1;
    localparam int SumW     = ProdW + 2;
    localparam int ShW      = SumW - FracBits;
    localparam int ValW     = ShW + 1;
    localparam int CfgDataW = 64;
    localparam int CfgAddrW = 5;

    localparam logic [PixW-1:0] ChanMax    = 8'd255;
    localparam logic [PixW-1:0] AlphaReset = 8'd255;

    typedef enum logic [1:0] {
        RegRed   = 2'd0,
        RegGreen = 2'd1,
        RegBlue  = 2'd2,
        RegAlpha = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [CoefW-1:0] offset;
        logic signed [CoefW-1:0] cv;
        logic signed [CoefW-1:0] cu;
        logic signed [CoefW-1:0] cy;
    } row_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

endpackage

/* design/yuv2argb_cfg.sv */
// Configuration register file with an APB-style access port.
module yuv2argb_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [yuv2argb_pkg::CfgAddrW-1:0] paddr,
    input  logic [yuv2argb_pkg::CfgDataW-1:0] pwdata,
    output logic [yuv2argb_pkg::CfgDataW-1:0] prdata,
    output logic                            pready,
    output yuv2argb_pkg::row_t              red_row,
    output yuv2argb_pkg::row_t              green_row,
    output yuv2argb_pkg::row_t              blue_row,
    output logic [yuv2argb_pkg::PixW-1:0]   alpha_value
);
    import yuv2argb_pkg::*;

    row_t            red_reg, green_reg, blue_reg;
    logic [PixW-1:0] alpha_reg;
    reg_idx_t        idx;
    logic            wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CfgAddrW-1:CfgAddrW-2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            alpha_reg <= AlphaReset;
        end
        else if (wr_en)
        begin
            unique case (idx)
                RegRed:   red_reg   <= row_t'(pwdata);
                RegGreen: green_reg <= row_t'(pwdata);
                RegBlue:  blue_reg  <= row_t'(pwdata);
                RegAlpha: alpha_reg <= pwdata[PixW-1:0];
                default:  alpha_reg <= alpha_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            RegRed:   prdata = CfgDataW'(red_reg);
            RegGreen: prdata = CfgDataW'(green_reg);
            RegBlue:  prdata = CfgDataW'(blue_reg);
            RegAlpha: prdata = {{(CfgDataW-PixW){1'b0}}, alpha_reg};
            default:  prdata = '0;
        endcase
    end

    assign red_row     = red_reg;
    assign green_row   = green_reg;
    assign blue_row    = blue_reg;
    assign alpha_value = alpha_reg;

endmodule

/* design/yuv2argb_chan.sv */
// Three-stage datapath for one color channel: products, scaled sum, offset and clamp.
module yuv2argb_chan (
    input  logic                          clk,
    input  yuv2argb_pkg::pipe_ctl_t       ctl,
    input  yuv2argb_pkg::row_t            row,
    input  logic [yuv2argb_pkg::PixW-1:0] luma,
    input  logic [yuv2argb_pkg::PixW-1:0] chroma_u,
    input  logic [yuv2argb_pkg::PixW-1:0] chroma_v,
    output logic [yuv2argb_pkg::PixW-1:0] chan
);
    import yuv2argb_pkg::*;

    logic signed [ProdW-1:0] py_reg, pu_reg, pv_reg;
    logic signed [ProdW-1:0] py_next, pu_next, pv_next;
    logic signed [SumW-1:0]  sum;
    logic signed [ShW-1:0]   sh_reg, sh_next;
    logic signed [ValW-1:0]  val;
    logic [PixW-1:0]         chan_reg, chan_next;

    always_comb
    begin
        py_next = ProdW'(row.cy * $signed({1'b0, luma}));
        pu_next = ProdW'(row.cu * $signed({1'b0, chroma_u}));
        pv_next = ProdW'(row.cv * $signed({1'b0, chroma_v}));
    end

    always_comb
    begin
        sum     = SumW'(py_reg) + SumW'(pu_reg) + SumW'(pv_reg);
        sh_next = sum[SumW-1:FracBits];
    end

    always_comb
    begin
        val = ValW'(sh_reg) + ValW'(row.offset);
        if (val < 0)
        begin
            chan_next = '0;
        end
        else if (val > $signed({{(ValW-PixW){1'b0}}, ChanMax}))
        begin
            chan_next = ChanMax;
        end
        else
        begin
            chan_next = val[PixW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            py_reg <= py_next;
            pu_reg <= pu_next;
            pv_reg <= pv_next;
        end
        if (ctl.ld2)
        begin
            sh_reg <= sh_next;
        end
        if (ctl.ld3)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

/* design/yuv_to_argb_matrix_convert.sv */
// Top level of the YUV to ARGB converter: handshake control and channel pipelines.
//
//   Channel  Kind        Carries
//   s_axis   stream in   luma, chroma_u, chroma_v
//   m_axis   stream out  red, green, blue, alpha_value
//   apb      config      red_row, green_row, blue_row, alpha_value
//
// A pixel's result is valid once it has passed the product, sum and output registers.
// One pixel enters per cycle through three stages unless the output stalls.
// Each stage moves when the next one is empty or moving, so a stalled output fills the
// pipeline before s_axis_tready falls, and no pixel is lost or repeated.
// Reset clears the stage valid bits and sets the rows to zero and alpha to 255.
module yuv_to_argb_matrix_convert (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,  // luma, chroma_u, chroma_v
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // red, green, blue, alpha_value
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [yuv2argb_pkg::CfgAddrW-1:0]   paddr,
    input  logic [yuv2argb_pkg::CfgDataW-1:0]   pwdata,
    output logic [yuv2argb_pkg::CfgDataW-1:0]   prdata,
    output logic                                pready
);
    import yuv2argb_pkg::*;

    row_t            red_row, green_row, blue_row;
    logic [PixW-1:0] alpha_value;
    logic [PixW-1:0] luma, chroma_u, chroma_v;
    logic [PixW-1:0] red, green, blue;
    logic            v1_reg, v2_reg, v3_reg;
    logic            rdy1, rdy2, rdy3;
    pipe_ctl_t       ctl;

    assign luma     = s_axis_tdata[PixW-1:0];
    assign chroma_u = s_axis_tdata[2*PixW-1:PixW];
    assign chroma_v = s_axis_tdata[3*PixW-1:2*PixW];

    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign ctl.ld1 = rdy1;
    assign ctl.ld2 = rdy2;
    assign ctl.ld3 = rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    yuv2argb_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .red_row     (red_row),
        .green_row   (green_row),
        .blue_row    (blue_row),
        .alpha_value (alpha_value)
    );

    yuv2argb_chan u_red (
        .clk      (clk),
        .ctl      (ctl),
        .row      (red_row),
        .luma     (luma),
        .chroma_u (chroma_u),
        .chroma_v (chroma_v),
        .chan     (red)
    );

    yuv2argb_chan u_green (
        .clk      (clk),
        .ctl      (ctl),
        .row      (green_row),
        .luma     (luma),
        .chroma_u (chroma_u),
        .chroma_v (chroma_v),
        .chan     (green)
    );

    yuv2argb_chan u_blue (
        .clk      (clk),
        .ctl      (ctl),
        .row      (blue_row),
        .luma     (luma),
        .chroma_u (chroma_u),
        .chroma_v (chroma_v),
        .chan     (blue)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {alpha_value, blue, green, red};

    a_ready_when_first_empty: assert property (
        @(posedge clk) disable iff (!rst_n) !v1_reg |-> s_axis_tready)
        else $error("Input stall with an empty first stage.");

    a_stage2_fills: assert property (
        @(posedge clk) disable iff (!rst_n) (v1_reg && !v2_reg) |=> v2_reg)
        else $error("Second stage did not take a waiting item.");

    a_out_replaced_by_stage2: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v3_reg && m_axis_tready) |=> (v3_reg == $past(v2_reg)))
        else $error("Output stage not refilled from the second stage.");

    a_input_moves_in: assert property (
        @(posedge clk) disable iff (!rst_n) (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("Accepted transfer missing from the first stage.");

endmodule
